// File: sv/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TCAOF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCAOF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tcaof_pkg.sv
package tcaof_pkg;

  typedef enum logic [1:0] {
    REQ_ENQ     = 2'd0,
    REQ_DEQ0    = 2'd1,
    REQ_DEQ1    = 2'd2,
    REQ_DEQ_OLD = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // per-cell load/shift controls
  typedef struct packed {
    logic ld;
    logic shift;
  } cell_ctrl_t;

endpackage

// File: sv/tcaof_if.sv
interface tcaof_in_if #(
  parameter int DATA_W = 32
);
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic              item_class;
  logic [DATA_W-1:0] item_data;

  modport source (output valid, output req_type, output item_class, output item_data,
                  input ready);
  modport sink   (input valid, input req_type, input item_class, input item_data,
                  output ready);
endinterface

interface tcaof_out_if #(
  parameter int DATA_W = 32
);
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              out_class;
  logic [DATA_W-1:0] out_data;

  modport source (output valid, output status, output out_class, output out_data,
                  input ready);
  modport sink   (input valid, input status, input out_class, input out_data,
                  output ready);
endinterface

// File: sv/tcaof_cell.sv
module tcaof_cell
  import tcaof_pkg::*;
#(
  parameter int W = 38
) (
  input  logic         clk,
  input  cell_ctrl_t   ctrl,
  input  logic [W-1:0] wr_val,
  input  logic [W-1:0] nbr_val,
  output logic [W-1:0] val
);

  logic [W-1:0] val_r;
  logic [W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ld) begin
      val_nxt = wr_val;
    end else if (ctrl.shift) begin
      val_nxt = nbr_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// File: sv/tcaof_queue.sv
module tcaof_queue
  import tcaof_pkg::*;
#(
  parameter int DEPTH   = 16,
  parameter int DATA_W  = 32,
  parameter int STAMP_W = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               enq,
  input  logic               deq,
  input  logic [DATA_W-1:0]  wr_data,
  input  logic [STAMP_W-1:0] wr_stamp,
  output logic [DATA_W-1:0]  head_data,
  output logic [STAMP_W-1:0] head_stamp,
  output logic               empty,
  output logic               full
);

  localparam int W     = DATA_W + STAMP_W;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic [W-1:0]     cell_val [DEPTH];
  logic [W-1:0]     wr_val;

  assign wr_val = {wr_stamp, wr_data};
  assign empty  = (fill_r == '0);
  assign full   = (fill_r == CNT_W'(DEPTH));

  // Head is always cell 0; a dequeue shifts the whole row one place down,
  // an enqueue loads the first free cell.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t   ctrl;
    logic [W-1:0] nbr;

    assign ctrl.ld    = enq && (fill_r == CNT_W'(i));
    assign ctrl.shift = deq;

    if (i == DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_val[i+1];
    end

    tcaof_cell #(.W(W)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .wr_val  (wr_val),
      .nbr_val (nbr),
      .val     (cell_val[i])
    );
  end

  always_comb begin
    fill_nxt = fill_r;
    if (enq) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (deq) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign head_data  = cell_val[0][DATA_W-1:0];
  assign head_stamp = cell_val[0][W-1:DATA_W];

endmodule

// File: sv/two_class_age_ordered_fifo.sv
// Two-class FIFO with oldest-first dequeue. Each class holds up to DEPTH
// payloads in a row of shift cells whose head always sits in the first
// cell; every successful enqueue is stamped with a STAMP_W-bit wrapping
// arrival count. Requests: enqueue to a class, dequeue class 0, dequeue
// class 1, or dequeue the older head (class 1 wins only when its stamp
// minus class 0's has the top bit set; ties go to class 0). Every request
// gives exactly one result with status ok, empty or full; errors and
// enqueues return class 0 and data 0. Each request is decided from the
// two head cells and the fill counts and lands in the result register
// the next cycle, so one request per cycle is sustained while results are
// taken. No clearing pass is needed after reset.
module two_class_age_ordered_fifo
  import tcaof_pkg::*;
#(
  parameter int DEPTH   = 16,
  parameter int DATA_W  = 32,
  parameter int STAMP_W = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  tcaof_in_if.sink    in_ch,
  tcaof_out_if.source out_ch
);

  logic               accept;
  logic               enq_a, enq_b, take_a, take_b;
  logic               empty_a, empty_b, full_a, full_b;
  logic [DATA_W-1:0]  head_data_a, head_data_b;
  logic [STAMP_W-1:0] head_stamp_a, head_stamp_b, stamp_diff;
  logic               b_older;
  status_t            status_c;
  req_t               req;

  logic [STAMP_W-1:0] arrival_r, arrival_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            status_r;
  logic               class_r;
  logic [DATA_W-1:0]  data_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign req         = req_t'(in_ch.req_type);

  assign stamp_diff = head_stamp_b - head_stamp_a;
  assign b_older    = stamp_diff[STAMP_W-1];

  always_comb begin
    enq_a    = 1'b0;
    enq_b    = 1'b0;
    take_a   = 1'b0;
    take_b   = 1'b0;
    status_c = ST_OK;
    case (req)
      REQ_ENQ: begin
        if (in_ch.item_class ? full_b : full_a) begin
          status_c = ST_FULL;
        end else begin
          enq_a = !in_ch.item_class;
          enq_b = in_ch.item_class;
        end
      end
      REQ_DEQ0: begin
        if (empty_a) status_c = ST_EMPTY;
        else         take_a   = 1'b1;
      end
      REQ_DEQ1: begin
        if (empty_b) status_c = ST_EMPTY;
        else         take_b   = 1'b1;
      end
      REQ_DEQ_OLD: begin
        if (empty_a && empty_b) begin
          status_c = ST_EMPTY;
        end else if (empty_b) begin
          take_a = 1'b1;
        end else if (empty_a) begin
          take_b = 1'b1;
        end else begin
          take_a = !b_older;
          take_b = b_older;
        end
      end
      default: status_c = ST_EMPTY;
    endcase
  end

  tcaof_queue #(.DEPTH(DEPTH), .DATA_W(DATA_W), .STAMP_W(STAMP_W)) u_queue_a (
    .clk        (clk),
    .rst_n      (rst_n),
    .enq        (accept && enq_a),
    .deq        (accept && take_a),
    .wr_data    (in_ch.item_data),
    .wr_stamp   (arrival_r),
    .head_data  (head_data_a),
    .head_stamp (head_stamp_a),
    .empty      (empty_a),
    .full       (full_a)
  );

  tcaof_queue #(.DEPTH(DEPTH), .DATA_W(DATA_W), .STAMP_W(STAMP_W)) u_queue_b (
    .clk        (clk),
    .rst_n      (rst_n),
    .enq        (accept && enq_b),
    .deq        (accept && take_b),
    .wr_data    (in_ch.item_data),
    .wr_stamp   (arrival_r),
    .head_data  (head_data_b),
    .head_stamp (head_stamp_b),
    .empty      (empty_b),
    .full       (full_b)
  );

  always_comb begin
    arrival_nxt = arrival_r;
    if (accept && (enq_a || enq_b)) begin
      arrival_nxt = arrival_r + STAMP_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      arrival_r   <= arrival_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_c;
      class_r  <= take_b;
      data_r   <= take_b ? head_data_b : (take_a ? head_data_a : '0);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.out_class = class_r;
  assign out_ch.out_data  = data_r;

endmodule

// File: sv/tcaof_checker.sv
`include "assert_macros.svh"

module tcaof_checker
  import tcaof_pkg::*;
#(
  parameter int DATA_W = 32
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_req_type,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_status,
  input logic              out_class,
  input logic [DATA_W-1:0] out_data
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  `TCAOF_ASSERT_NOW(a_err_zero, out_valid && (out_status != ST_OK), (out_data == '0) && (out_class == 1'b0), "error result carries data")
  `TCAOF_ASSERT_NOW(a_status_code, out_valid, (out_status == ST_OK) || (out_status == ST_EMPTY) || (out_status == ST_FULL), "bad status code")
  `TCAOF_ASSERT_NEXT(a_accept_result, in_acc, out_valid, "request gave no result")
  `TCAOF_ASSERT_NEXT(a_enq_result, in_acc && (in_req_type == REQ_ENQ), ((out_status == ST_OK) || (out_status == ST_FULL)) && (out_data == '0), "bad enqueue result")
  `TCAOF_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_data) && $stable(out_status), "stalled result changed")

endmodule

bind two_class_age_ordered_fifo tcaof_checker #(.DATA_W(DATA_W)) u_tcaof_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_class   (out_ch.out_class),
  .out_data    (out_ch.out_data)
);

// File: dv/two_class_age_ordered_fifo_chk.sv
module tcaof_order_checker
  import tcaof_pkg::*;
#(
  parameter int DEPTH   = 16,
  parameter int DATA_W  = 32,
  parameter int STAMP_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic              in_item_class,
  input  logic [DATA_W-1:0] in_item_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        out_status,
  input  logic              out_class,
  input  logic [DATA_W-1:0] out_data,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    status_t           status;
    logic              cls;
    logic [DATA_W-1:0] data;
  } response_t;

  response_t response_q[$];
  response_t want_r;

  logic [DATA_W-1:0]  payload_a [DEPTH];
  logic [DATA_W-1:0]  payload_b [DEPTH];
  logic [STAMP_W-1:0] stamp_a   [DEPTH];
  logic [STAMP_W-1:0] stamp_b   [DEPTH];
  int                 head_a, tail_a, fill_a;
  int                 head_b, tail_b, fill_b;
  logic [STAMP_W-1:0] arrivals;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic int next_slot(input int p);
    return (p == DEPTH - 1) ? 0 : p + 1;
  endfunction

  task automatic predict_response(input req_t req, input logic cls,
                                  input logic [DATA_W-1:0] data);
    response_t          r;
    logic               take_b;
    logic [STAMP_W-1:0] gap;
    r.status = ST_OK;
    r.cls    = 1'b0;
    r.data   = '0;
    if (req == REQ_ENQ) begin
      if (cls ? (fill_b == DEPTH) : (fill_a == DEPTH)) begin
        r.status = ST_FULL;
      end else begin
        if (!cls) begin
          payload_a[tail_a] = data;
          stamp_a[tail_a]   = arrivals;
          tail_a            = next_slot(tail_a);
          fill_a++;
        end else begin
          payload_b[tail_b] = data;
          stamp_b[tail_b]   = arrivals;
          tail_b            = next_slot(tail_b);
          fill_b++;
        end
        arrivals = arrivals + 1'b1;
      end
    end else begin
      if (req == REQ_DEQ0) begin
        take_b = 1'b0;
      end else if (req == REQ_DEQ1) begin
        take_b = 1'b1;
      end else if (fill_a == 0) begin
        take_b = 1'b1;
      end else if (fill_b == 0) begin
        take_b = 1'b0;
      end else begin
        // serial compare: class 1 wins only if its stamp is strictly behind
        gap    = stamp_b[head_b] - stamp_a[head_a];
        take_b = gap[STAMP_W-1];
      end
      if (take_b ? (fill_b == 0) : (fill_a == 0)) begin
        r.status = ST_EMPTY;
      end else if (!take_b) begin
        r.data = payload_a[head_a];
        head_a = next_slot(head_a);
        fill_a--;
      end else begin
        r.cls  = 1'b1;
        r.data = payload_b[head_b];
        head_b = next_slot(head_b);
        fill_b--;
      end
    end
    response_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head_a   = 0;
      tail_a   = 0;
      fill_a   = 0;
      head_b   = 0;
      tail_b   = 0;
      fill_b   = 0;
      arrivals = '0;
      response_q.delete();
      pending  = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_response(req_t'(in_req_type), in_item_class, in_item_data);
      end
      if (out_valid && out_ready) begin
        if (response_q.size() == 0) begin
          report_mismatch("response with no request outstanding", out_data, '0);
        end else begin
          want_r = response_q.pop_front();
          if (out_status !== want_r.status) begin
            report_mismatch("status", DATA_W'(out_status), DATA_W'(want_r.status));
          end
          if (out_class !== want_r.cls) begin
            report_mismatch("out_class", DATA_W'(out_class), DATA_W'(want_r.cls));
          end
          if (out_data !== want_r.data) begin
            report_mismatch("out_data", out_data, want_r.data);
          end
        end
      end
      pending = response_q.size();
    end
  end

endmodule

// File: dv/two_class_age_ordered_fifo_tb.sv
module two_class_age_ordered_fifo_tb;
  import tcaof_pkg::*;

  localparam int DEPTH      = 16;
  localparam int DATA_W     = 32;
  localparam int STAMP_W    = 6;
  localparam int TOTAL_REQS = 1400;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   sent;
  int   sender_idle_pct;
  int   recv_idle_pct;

  tcaof_in_if  #(.DATA_W(DATA_W)) in_ch ();
  tcaof_out_if #(.DATA_W(DATA_W)) out_ch ();

  two_class_age_ordered_fifo #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W),
    .STAMP_W(STAMP_W)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  tcaof_order_checker #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W),
    .STAMP_W(STAMP_W)
  ) u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_req_type  (in_ch.req_type),
    .in_item_class(in_ch.item_class),
    .in_item_data (in_ch.item_data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_status   (out_ch.status),
    .out_class    (out_ch.out_class),
    .out_data     (out_ch.out_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [DATA_W-1:0] pick_payload();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic send_req(input req_t req, input logic cls, input logic [DATA_W-1:0] data);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.item_class <= cls;
    in_ch.item_data  <= data;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // hold off new requests until every response is back
  task automatic drain_wait();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic enq(input logic cls, input logic [DATA_W-1:0] data);
    send_req(REQ_ENQ, cls, data);
  endtask

  task automatic deq(input req_t req);
    send_req(req, 1'($urandom), pick_payload());
  endtask

  function automatic req_t pick_dequeue();
    case ($urandom_range(2))
      0:       return REQ_DEQ0;
      1:       return REQ_DEQ1;
      default: return REQ_DEQ_OLD;
    endcase
  endfunction

  task automatic run_burst();
    int n;
    logic cls;
    case ($urandom_range(9))
      0, 1: begin
        // fill one class, often past full
        cls = 1'($urandom);
        n   = $urandom_range(1, DEPTH + 3);
        repeat (n) enq(cls, pick_payload());
      end
      2, 3: begin
        n = $urandom_range(1, DEPTH + 3);
        repeat (n) deq(pick_dequeue());
      end
      4: begin
        // let class 0 head age far behind class 1 traffic, then race the heads
        enq(1'b0, pick_payload());
        n = $urandom_range(10, 40);
        repeat (n) begin
          enq(1'b1, pick_payload());
          deq(REQ_DEQ1);
        end
        enq(1'b1, pick_payload());
        repeat ($urandom_range(1, 4)) deq(REQ_DEQ_OLD);
      end
      5, 6: begin
        n = $urandom_range(2, 12);
        repeat (n) begin
          enq(1'($urandom), pick_payload());
          if ($urandom_range(1)) deq(REQ_DEQ_OLD);
        end
      end
      default: begin
        n = $urandom_range(4, 20);
        repeat (n) begin
          if ($urandom_range(1)) enq(1'($urandom), pick_payload());
          else deq(pick_dequeue());
        end
      end
    endcase
    if ($urandom_range(11) == 0) drain_wait();
  endtask

  task automatic directed_reqs();
    deq(REQ_DEQ0);
    deq(REQ_DEQ1);
    deq(REQ_DEQ_OLD);
    enq(1'b0, '0);
    enq(1'b1, '1);
    deq(REQ_DEQ_OLD);
    deq(REQ_DEQ_OLD);
    enq(1'b1, 32'h5555_5555);
    enq(1'b0, 32'hAAAA_AAAA);
    deq(REQ_DEQ_OLD);
    deq(REQ_DEQ_OLD);
    deq(REQ_DEQ_OLD);
    enq(1'b0, 32'h8000_0001);
    deq(REQ_DEQ1);
    deq(REQ_DEQ0);
    enq(1'b1, 32'h7FFF_FFFE);
    deq(REQ_DEQ0);
    deq(REQ_DEQ1);
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    sent             = 0;
    sender_idle_pct  = 25;
    recv_idle_pct    = 67;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_ENQ;
    in_ch.item_class = 1'b0;
    in_ch.item_data  = '0;
    out_ch.ready     = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 25;
          recv_idle_pct   = 67;
        end
        1: begin
          sender_idle_pct = 67;
          recv_idle_pct   = 25;
        end
        default: begin
          sender_idle_pct = 0;
          recv_idle_pct   = 0;
        end
      endcase
      if (ph == 0) directed_reqs();
      while (sent < (ph + 1) * TOTAL_REQS / 3) run_burst();
      drain_wait();
    end

    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
